// File: design/key_value_text_tokenizer_defines.svh
// Assertion macros used by the tokenizer checker.
`ifndef KEY_VALUE_TEXT_TOKENIZER_DEFINES_SVH
`define KEY_VALUE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kvt_pkg.sv
// Types and constants shared by the key/value text tokenizer modules.
package kvt_pkg;

  // Scanner phases of one token.
  typedef enum logic [3:0] {
    M_START      = 4'd0,
    M_CMT_START  = 4'd1,
    M_NAME       = 4'd2,
    M_AFTER_NAME = 4'd3,
    M_CMT_NAME   = 4'd4,
    M_EQ_SKIP    = 4'd5,
    M_CMT_EQ     = 4'd6,
    M_QUOTED     = 4'd7,
    M_UNQ        = 4'd8
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    K_NAME  = 2'd0,
    K_VALUE = 2'd1,
    K_DONE  = 2'd2,
    K_END   = 2'd3
  } kind_e;

  // Separator codes carried by a completion.
  typedef enum logic [1:0] {
    S_NONE   = 2'd0,
    S_COLON  = 2'd1,
    S_EQUALS = 2'd2,
    S_SEMI   = 2'd3
  } sep_e;

  // Character constants.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Number sent when no atoi value applies.
  localparam logic [31:0] NUM_NONE = 32'hFFFF_FFFF;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    sep_e        sep;
    logic [31:0] number;
  } res_t;

  // All results caused by one input byte (one or two).
  typedef struct packed {
    logic has_second;
    res_t r0;
    res_t r1;
  } step_t;

  // Outcome of one scanner pass over a byte.
  typedef struct packed {
    mode_e      next_mode;
    logic       again;
    logic [1:0] n_emit;
    res_t       e0;
    res_t       e1;
    logic       clr;
    logic       feed;
  } pass_t;

endpackage

// File: design/kvt_front.sv
// Front part: scans each byte, keeps the token state and the atoi accumulator.
module kvt_front import kvt_pkg::*; #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_req_i,
  input  logic       q_full_i,
  output logic       push_o,
  output step_t      push_data_o
);

  mode_e                  mode_q, mode_d;
  logic [NUMBER_BITS-1:0] acc_value_q, acc_value_d;
  logic                   acc_neg_q, acc_neg_d;
  logic                   acc_stop_q, acc_stop_d;
  logic                   begun_q, begun_d;

  logic                   accept;
  pass_t                  p0, p1, p2;
  logic                   act1, act2;
  mode_e                  chain_mode;
  logic                   chain_clr, chain_feed;

  logic [NUMBER_BITS-1:0] acc_mag;
  logic signed [NUMBER_BITS-1:0] acc_signed;
  logic [31:0]            acc_num;
  logic [NUMBER_BITS-1:0] acc_x10, acc_fed;
  logic [3:0]             digit_val;
  logic                   is_digit;
  logic [NUMBER_BITS-1:0] feed_value;
  logic                   feed_neg, feed_stop, feed_begun;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic ends_unq(logic [7:0] c);
    return (c == CH_NUL) || is_ws(c) || (c == CH_COLON) || (c == CH_SEMI) || (c == CH_EQ);
  endfunction

  function automatic res_t mk(kind_e k, logic [7:0] c, sep_e s, logic [31:0] num);
    res_t r;
    r.kind   = k;
    r.ch     = c;
    r.sep    = s;
    r.number = num;
    return r;
  endfunction

  // One pass of the scanner over byte c in phase m.
  function automatic pass_t do_pass(mode_e m, logic [7:0] c, logic [31:0] accn);
    pass_t p;
    res_t  done_none;
    res_t  end_res;
    done_none = mk(K_DONE, CH_NUL, S_NONE, NUM_NONE);
    end_res   = mk(K_END, CH_NUL, S_NONE, NUM_NONE);
    p.next_mode = m;
    p.again     = 1'b0;
    p.n_emit    = 2'd0;
    p.e0        = end_res;
    p.e1        = end_res;
    p.clr       = 1'b0;
    p.feed      = 1'b0;
    unique case (m)
      M_START: begin
        if (is_ws(c)) begin
          p.next_mode = M_START;
        end else if (c == CH_HASH) begin
          p.next_mode = M_CMT_START;
        end else if (c == CH_NUL) begin
          p.n_emit = 2'd1;
          p.clr    = 1'b1;
        end else if (c == CH_SEMI) begin
          p.n_emit = 2'd1;
          p.e0     = mk(K_DONE, CH_NUL, S_SEMI, NUM_NONE);
        end else if (c == CH_COLON) begin
          p.n_emit = 2'd1;
          p.e0     = mk(K_DONE, CH_NUL, S_COLON, NUM_NONE);
        end else if (c == CH_EQ) begin
          p.clr       = 1'b1;
          p.next_mode = M_EQ_SKIP;
        end else begin
          p.n_emit    = 2'd1;
          p.e0        = mk(K_NAME, c, S_NONE, NUM_NONE);
          p.next_mode = M_NAME;
        end
      end
      M_CMT_START: begin
        if (c == CH_NUL) begin
          p.n_emit    = 2'd1;
          p.clr       = 1'b1;
          p.next_mode = M_START;
        end else if (c == CH_LF) begin
          p.next_mode = M_AFTER_NAME;
        end
      end
      M_NAME: begin
        if (c == CH_COLON) begin
          p.n_emit    = 2'd1;
          p.e0        = mk(K_DONE, CH_NUL, S_COLON, NUM_NONE);
          p.next_mode = M_START;
        end else if (c == CH_EQ) begin
          p.clr       = 1'b1;
          p.next_mode = M_EQ_SKIP;
        end else if (ends_unq(c)) begin
          p.next_mode = M_AFTER_NAME;
          p.again     = 1'b1;
        end else begin
          p.n_emit = 2'd1;
          p.e0     = mk(K_NAME, c, S_NONE, NUM_NONE);
        end
      end
      M_AFTER_NAME: begin
        if (is_ws(c)) begin
          p.next_mode = M_AFTER_NAME;
        end else if (c == CH_HASH) begin
          p.next_mode = M_CMT_NAME;
        end else if (c == CH_NUL) begin
          p.n_emit    = 2'd2;
          p.e0        = done_none;
          p.e1        = end_res;
          p.clr       = 1'b1;
          p.next_mode = M_START;
        end else if (c == CH_COLON) begin
          p.n_emit    = 2'd1;
          p.e0        = mk(K_DONE, CH_NUL, S_COLON, NUM_NONE);
          p.next_mode = M_START;
        end else if (c == CH_EQ) begin
          p.clr       = 1'b1;
          p.next_mode = M_EQ_SKIP;
        end else begin
          p.n_emit    = 2'd1;
          p.e0        = done_none;
          p.next_mode = M_START;
          p.again     = 1'b1;
        end
      end
      M_CMT_NAME: begin
        if (c == CH_NUL) begin
          p.next_mode = M_AFTER_NAME;
          p.again     = 1'b1;
        end else if (c == CH_LF) begin
          p.n_emit    = 2'd1;
          p.e0        = done_none;
          p.next_mode = M_START;
          p.again     = 1'b1;
        end
      end
      M_EQ_SKIP: begin
        if (is_ws(c)) begin
          p.next_mode = M_EQ_SKIP;
        end else if (c == CH_HASH) begin
          p.next_mode = M_CMT_EQ;
        end else if (c == CH_NUL) begin
          p.n_emit    = 2'd2;
          p.e0        = done_none;
          p.e1        = end_res;
          p.clr       = 1'b1;
          p.next_mode = M_START;
        end else if (c == CH_QUOTE) begin
          p.next_mode = M_QUOTED;
        end else begin
          p.next_mode = M_UNQ;
          p.again     = 1'b1;
        end
      end
      M_CMT_EQ: begin
        if (c == CH_NUL) begin
          p.next_mode = M_EQ_SKIP;
          p.again     = 1'b1;
        end else if (c == CH_LF) begin
          p.next_mode = M_UNQ;
          p.again     = 1'b1;
        end
      end
      M_QUOTED: begin
        if (c == CH_NUL) begin
          p.n_emit    = 2'd2;
          p.e0        = mk(K_DONE, CH_NUL, S_EQUALS, NUM_NONE);
          p.e1        = end_res;
          p.clr       = 1'b1;
          p.next_mode = M_START;
        end else if (c == CH_QUOTE) begin
          p.n_emit    = 2'd1;
          p.e0        = mk(K_DONE, CH_NUL, S_EQUALS, NUM_NONE);
          p.next_mode = M_START;
        end else begin
          p.n_emit = 2'd1;
          p.e0     = mk(K_VALUE, c, S_NONE, NUM_NONE);
        end
      end
      M_UNQ: begin
        if (ends_unq(c)) begin
          p.n_emit    = 2'd1;
          p.e0        = mk(K_DONE, CH_NUL, S_EQUALS, accn);
          p.clr       = 1'b1;
          p.next_mode = M_START;
          p.again     = 1'b1;
        end else begin
          p.n_emit = 2'd1;
          p.e0     = mk(K_VALUE, c, S_NONE, NUM_NONE);
          p.feed   = 1'b1;
        end
      end
      default: begin
        p.clr       = 1'b1;
        p.next_mode = M_START;
        p.again     = 1'b1;
      end
    endcase
    return p;
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Signed atoi result of the accumulator, sign-extended or cut to 32 bits.
  always_comb begin
    acc_mag    = acc_neg_q ? (~acc_value_q + 1'b1) : acc_value_q;
    acc_signed = signed'(acc_mag);
    acc_num    = 32'(acc_signed);
  end

  // Up to three chained passes over the byte.
  always_comb begin
    p0   = do_pass(mode_q, byte_req_i, acc_num);
    p1   = do_pass(p0.next_mode, byte_req_i, acc_num);
    p2   = do_pass(p1.next_mode, byte_req_i, acc_num);
    act1 = p0.again;
    act2 = p0.again && p1.again;
    chain_mode = act2 ? p2.next_mode : (act1 ? p1.next_mode : p0.next_mode);
    chain_clr  = p0.clr || (act1 && p1.clr) || (act2 && p2.clr);
    chain_feed = p0.feed || (act1 && p1.feed) || (act2 && p2.feed);
  end

  // Accumulator step for one value character.
  always_comb begin
    is_digit   = (byte_req_i >= CH_ZERO) && (byte_req_i <= CH_NINE);
    digit_val  = 4'(byte_req_i - CH_ZERO);
    acc_x10    = (acc_value_q << 3) + (acc_value_q << 1);
    acc_fed    = acc_x10 + NUMBER_BITS'(digit_val);
    feed_value = acc_value_q;
    feed_neg   = acc_neg_q;
    feed_stop  = acc_stop_q;
    feed_begun = begun_q;
    if (!acc_stop_q) begin
      if (!begun_q) begin
        if ((byte_req_i == CH_VT) || (byte_req_i == CH_FF)) begin
          feed_begun = 1'b0;
        end else if ((byte_req_i == CH_PLUS) || (byte_req_i == CH_MINUS)) begin
          feed_neg   = (byte_req_i == CH_MINUS);
          feed_begun = 1'b1;
        end else if (!is_digit) begin
          feed_stop = 1'b1;
        end else begin
          feed_begun = 1'b1;
          feed_value = acc_fed;
        end
      end else if (!is_digit) begin
        feed_stop = 1'b1;
      end else begin
        feed_value = acc_fed;
      end
    end
  end

  // Next state of the scanner and the accumulator.
  always_comb begin
    mode_d      = mode_q;
    acc_value_d = acc_value_q;
    acc_neg_d   = acc_neg_q;
    acc_stop_d  = acc_stop_q;
    begun_d     = begun_q;
    if (accept) begin
      mode_d = chain_mode;
      if (chain_feed) begin
        acc_value_d = feed_value;
        acc_neg_d   = feed_neg;
        acc_stop_d  = feed_stop;
        begun_d     = feed_begun;
      end else if (chain_clr) begin
        acc_value_d = '0;
        acc_neg_d   = 1'b0;
        acc_stop_d  = 1'b0;
        begun_d     = 1'b0;
      end
    end
  end

  // Gather the results of all passes into one queue record, at most two.
  always_comb begin
    res_t       slot0, slot1;
    logic [1:0] cnt;
    slot0 = p0.e0;
    slot1 = p0.e1;
    cnt   = p0.n_emit;
    if (act1 && (p1.n_emit != 2'd0)) begin
      if (cnt == 2'd0) begin
        slot0 = p1.e0;
        slot1 = p1.e1;
        cnt   = p1.n_emit;
      end else if (cnt == 2'd1) begin
        slot1 = p1.e0;
        cnt   = 2'd2;
      end
    end
    if (act2 && (p2.n_emit != 2'd0)) begin
      if (cnt == 2'd0) begin
        slot0 = p2.e0;
        slot1 = p2.e1;
        cnt   = p2.n_emit;
      end else if (cnt == 2'd1) begin
        slot1 = p2.e0;
        cnt   = 2'd2;
      end
    end
    push_o                 = accept && (cnt != 2'd0);
    push_data_o.has_second = (cnt == 2'd2);
    push_data_o.r0         = slot0;
    push_data_o.r1         = slot1;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_START;
      acc_value_q <= '0;
      acc_neg_q   <= 1'b0;
      acc_stop_q  <= 1'b0;
      begun_q     <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      acc_value_q <= acc_value_d;
      acc_neg_q   <= acc_neg_d;
      acc_stop_q  <= acc_stop_d;
      begun_q     <= begun_d;
    end
  end

endmodule

// File: design/kvt_queue.sv
// Short queue of per-byte result records between the front and the back.
module kvt_queue import kvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output step_t head_o
);

  step_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/kvt_back.sv
// Back part: splits each record into result beats and holds the output register.
module kvt_back import kvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  head_valid_i,
  input  step_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  out_res_o,
  output logic  out_last_o
);

  logic idx_q, idx_d;
  logic valid_q, valid_d;
  res_t res_q;
  logic last_q;
  logic load;
  logic is_last;
  res_t sel;

  // Pick the next beat of the head record.
  always_comb begin
    load    = head_valid_i && (!valid_q || !out_stall_i);
    sel     = idx_q ? head_i.r1 : head_i.r0;
    is_last = !head_i.has_second || idx_q;
    pop_o   = load && is_last;
    idx_d   = idx_q;
    if (load) begin
      idx_d = !is_last;
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= sel;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

// File: design/key_value_text_tokenizer.sv
// Top level of the key/value text tokenizer.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------------
//  input    | in        | in_valid_i/in_stall_o | byte_req_i
//  output   | out       | out_valid_o/out_stall_i | kind_o, ch_o, sep_code_o, number_o, last_o
//
// A byte is accepted every cycle while the two-record queue has room; its results
// are written into the queue and then loaded into the output register once it is free.
// A byte that causes two results gives two output beats, one after the other.
// Output stalls back up into the queue and then into in_stall_o.
// Reset is asynchronous and leaves the scanner at token start with an empty queue.
module key_value_text_tokenizer import kvt_pkg::*; #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         ch_o,
  output logic [1:0]         sep_code_o,
  output logic signed [31:0] number_o,
  output logic               last_o
);

  logic  push, q_full, pop, head_valid;
  step_t push_data, head;
  res_t  out_res;

  kvt_front #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_req_i (byte_req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  kvt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  kvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_o)
  );

  // Spread the result beat over the field ports.
  assign kind_o     = out_res.kind;
  assign ch_o       = out_res.ch;
  assign sep_code_o = out_res.sep;
  assign number_o   = signed'(out_res.number);

endmodule

// File: design/kvt_checker.sv
// Port-level checker for the key/value text tokenizer, with its bind.
`include "key_value_text_tokenizer_defines.svh"

module kvt_checker import kvt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [7:0]         byte_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic [7:0]         ch_o,
  input logic [1:0]         sep_code_o,
  input logic signed [31:0] number_o,
  input logic               last_o
);

  // A stalled result beat holds its payload.
  `KVT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable({kind_o, ch_o, sep_code_o, number_o, last_o}), "stalled result beat changed")

  // End of text is always the final result of its byte.
  `KVT_ASSERT_IMPL(a_end_last, out_valid_o && (kind_o == K_END), last_o, "end of text not marked last")

  // Completions and end results carry no character.
  `KVT_ASSERT_IMPL(a_ch_zero, out_valid_o && ((kind_o == K_DONE) || (kind_o == K_END)), ch_o == CH_NUL, "character on a non-character result")

  // A separator code appears only on a completion.
  `KVT_ASSERT_IMPL(a_sep_done, out_valid_o && (kind_o != K_DONE), sep_code_o == S_NONE, "separator on a non-completion result")

  // A number other than all ones comes only with an equals completion.
  `KVT_ASSERT_IMPL(a_num_none, out_valid_o && !((kind_o == K_DONE) && (sep_code_o == S_EQUALS)), number_o == signed'(NUM_NONE), "number on a result without a value")

endmodule

bind key_value_text_tokenizer kvt_checker u_checker (.*);

// File: sim/key_value_text_tokenizer_tb.sv
// Self-checking testbench for the key/value text tokenizer: directed texts, then random token streams.
module key_value_text_tokenizer_tb;
  import kvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_BITS    = 32;
  localparam logic [63:0] NUM_MASK    = {64{1'b1}} >> (64 - NUM_BITS);
  localparam int          QUIET_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 16;

  // One expected or observed result beat.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    sep_e        sep;
    logic [31:0] number;
    logic        last;
  } token_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_req_i  = 8'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [7:0]         ch_o;
  logic [1:0]         sep_code_o;
  logic signed [31:0] number_o;
  logic               last_o;

  // Expected result beats, oldest first.
  token_t token_q[$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Scanner state of the predictor.
  mode_e       scan_mode;
  logic [63:0] acc_val;
  logic        acc_neg;
  logic        acc_stop;
  logic        val_begun;
  token_t      step_res [2];
  int          step_n;

  key_value_text_tokenizer #(
    .NUMBER_BITS(NUM_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_req_i (byte_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .ch_o       (ch_o),
    .sep_code_o (sep_code_o),
    .number_o   (number_o),
    .last_o     (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic ends_value(logic [7:0] c);
    return c == CH_NUL || is_space(c) || c == CH_COLON || c == CH_SEMI || c == CH_EQ;
  endfunction

  task automatic clear_number();
    acc_val   = 64'd0;
    acc_neg   = 1'b0;
    acc_stop  = 1'b0;
    val_begun = 1'b0;
  endtask

  task automatic restart_scan();
    scan_mode = M_START;
    clear_number();
  endtask

  // Follows atoi: leading VT/FF, one sign, then digits up to the first non-digit.
  task automatic feed_number(input logic [7:0] c);
    logic is_digit;
    is_digit = c >= CH_ZERO && c <= CH_NINE;
    if (acc_stop) return;
    if (!val_begun) begin
      if (c == CH_VT || c == CH_FF) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        acc_neg   = (c == CH_MINUS);
        val_begun = 1'b1;
        return;
      end
      if (!is_digit) begin
        acc_stop = 1'b1;
        return;
      end
      val_begun = 1'b1;
    end
    if (!is_digit) begin
      acc_stop = 1'b1;
      return;
    end
    acc_val = (acc_val * 64'd10 + ({56'd0, c} - {56'd0, CH_ZERO})) & NUM_MASK;
  endtask

  // Wraps at NUM_BITS, then sign-extends and keeps the low 32 bits.
  function automatic logic [31:0] number_value();
    logic [63:0] v;
    v = acc_neg ? ((64'd0 - acc_val) & NUM_MASK) : (acc_val & NUM_MASK);
    if (v[NUM_BITS-1]) v = v | ~NUM_MASK;
    return v[31:0];
  endfunction

  task automatic add_result(input kind_e k, input logic [7:0] c, input sep_e s,
                            input logic [31:0] num);
    if (step_n < 2) begin
      step_res[step_n] = '{kind: k, ch: c, sep: s, number: num, last: 1'b0};
      step_n++;
    end
  endtask

  // Works out the result beats of one accepted byte and queues them.
  task automatic scan_byte(input logic [7:0] c);
    logic again;
    int   pass;
    step_n = 0;
    again  = 1'b1;
    for (pass = 0; pass < 3 && again; pass++) begin
      again = 1'b0;
      case (scan_mode)
        M_START: begin
          if (!is_space(c)) begin
            if (c == CH_HASH) scan_mode = M_CMT_START;
            else if (c == CH_NUL) begin
              add_result(K_END, 8'd0, S_NONE, NUM_NONE);
              restart_scan();
            end else if (c == CH_SEMI) add_result(K_DONE, 8'd0, S_SEMI, NUM_NONE);
            else if (c == CH_COLON) add_result(K_DONE, 8'd0, S_COLON, NUM_NONE);
            else if (c == CH_EQ) begin
              clear_number();
              scan_mode = M_EQ_SKIP;
            end else begin
              add_result(K_NAME, c, S_NONE, NUM_NONE);
              scan_mode = M_NAME;
            end
          end
        end
        M_CMT_START: begin
          if (c == CH_NUL) begin
            add_result(K_END, 8'd0, S_NONE, NUM_NONE);
            restart_scan();
          end else if (c == CH_LF) scan_mode = M_AFTER_NAME;
        end
        M_NAME: begin
          if (c == CH_COLON) begin
            add_result(K_DONE, 8'd0, S_COLON, NUM_NONE);
            scan_mode = M_START;
          end else if (c == CH_EQ) begin
            clear_number();
            scan_mode = M_EQ_SKIP;
          end else if (ends_value(c)) begin
            scan_mode = M_AFTER_NAME;
            again     = 1'b1;
          end else add_result(K_NAME, c, S_NONE, NUM_NONE);
        end
        M_AFTER_NAME: begin
          if (!is_space(c)) begin
            if (c == CH_HASH) scan_mode = M_CMT_NAME;
            else if (c == CH_NUL) begin
              add_result(K_DONE, 8'd0, S_NONE, NUM_NONE);
              add_result(K_END, 8'd0, S_NONE, NUM_NONE);
              restart_scan();
            end else if (c == CH_COLON) begin
              add_result(K_DONE, 8'd0, S_COLON, NUM_NONE);
              scan_mode = M_START;
            end else if (c == CH_EQ) begin
              clear_number();
              scan_mode = M_EQ_SKIP;
            end else begin
              add_result(K_DONE, 8'd0, S_NONE, NUM_NONE);
              scan_mode = M_START;
              again     = 1'b1;
            end
          end
        end
        M_CMT_NAME: begin
          if (c == CH_NUL) begin
            scan_mode = M_AFTER_NAME;
            again     = 1'b1;
          end else if (c == CH_LF) begin
            add_result(K_DONE, 8'd0, S_NONE, NUM_NONE);
            scan_mode = M_START;
            again     = 1'b1;
          end
        end
        M_EQ_SKIP: begin
          if (!is_space(c)) begin
            if (c == CH_HASH) scan_mode = M_CMT_EQ;
            else if (c == CH_NUL) begin
              add_result(K_DONE, 8'd0, S_NONE, NUM_NONE);
              add_result(K_END, 8'd0, S_NONE, NUM_NONE);
              restart_scan();
            end else if (c == CH_QUOTE) scan_mode = M_QUOTED;
            else begin
              scan_mode = M_UNQ;
              again     = 1'b1;
            end
          end
        end
        M_CMT_EQ: begin
          if (c == CH_NUL) begin
            scan_mode = M_EQ_SKIP;
            again     = 1'b1;
          end else if (c == CH_LF) begin
            scan_mode = M_UNQ;
            again     = 1'b1;
          end
        end
        M_QUOTED: begin
          if (c == CH_NUL) begin
            add_result(K_DONE, 8'd0, S_EQUALS, NUM_NONE);
            add_result(K_END, 8'd0, S_NONE, NUM_NONE);
            restart_scan();
          end else if (c == CH_QUOTE) begin
            add_result(K_DONE, 8'd0, S_EQUALS, NUM_NONE);
            scan_mode = M_START;
          end else add_result(K_VALUE, c, S_NONE, NUM_NONE);
        end
        M_UNQ: begin
          if (ends_value(c)) begin
            add_result(K_DONE, 8'd0, S_EQUALS, number_value());
            clear_number();
            scan_mode = M_START;
            again     = 1'b1;
          end else begin
            add_result(K_VALUE, c, S_NONE, NUM_NONE);
            feed_number(c);
          end
        end
        default: begin
          restart_scan();
          again = 1'b1;
        end
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------- driving

  // Offers one byte, waits until it is accepted and predicts its results.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_req_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    scan_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // A byte that can sit inside a name or an unquoted value.
  function automatic logic [7:0] rand_plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (ends_value(c) || c == CH_HASH || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == avoid);
    return c;
  endfunction

  task automatic send_spaces();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(3))
        0:       send_byte(CH_SPACE);
        1:       send_byte(CH_TAB);
        2:       send_byte(CH_CR);
        default: send_byte(CH_LF);
      endcase
    end
  endtask

  task automatic send_comment();
    int n;
    n = $urandom_range(0, 5);
    send_byte(CH_HASH);
    repeat (n) send_byte(rand_byte_except(CH_LF));
    send_byte(CH_LF);
  endtask

  task automatic send_filler();
    if ($urandom_range(4) == 0) send_comment();
    else send_spaces();
  endtask

  task automatic send_value();
    int n;
    if ($urandom_range(3) == 0) send_filler();
    if ($urandom_range(9) < 3) begin
      // Quoted value, now and then cut off by the end of text.
      n = $urandom_range(0, 6);
      send_byte(CH_QUOTE);
      repeat (n) send_byte(rand_byte_except(CH_QUOTE));
      send_byte(($urandom_range(19) == 0) ? CH_NUL : CH_QUOTE);
    end else begin
      if ($urandom_range(7) == 0) send_byte($urandom_range(1) ? CH_VT : CH_FF);
      case ($urandom_range(3))
        0:       send_byte(CH_PLUS);
        1:       send_byte(CH_MINUS);
        default: ;
      endcase
      // Mostly short numbers; a few long enough to wrap.
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 10);
      repeat (n) send_byte(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(9) == 0) begin
        send_byte(rand_plain_char());
        send_byte(CH_ZERO + 8'($urandom_range(9)));
      end
      case ($urandom_range(9))
        0:       send_byte(CH_SPACE);
        1:       send_byte(CH_TAB);
        2:       send_byte(CH_CR);
        3:       send_byte(CH_LF);
        4, 5:    send_byte(CH_SEMI);
        6:       send_byte(CH_COLON);
        7:       send_byte(CH_EQ);
        8:       send_byte(CH_NUL);
        default: ;
      endcase
    end
  endtask

  // One well-formed token with random content, or a burst of raw bytes.
  task automatic send_random_token();
    int n;
    int sel;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    sel = $urandom_range(9);
    if (sel == 6 || sel == 7) send_spaces();
    else if (sel == 8) send_comment();
    else if (sel == 9) send_byte(CH_SEMI);
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n) send_byte(rand_plain_char());
    if ($urandom_range(4) == 0) send_filler();
    sel = $urandom_range(9);
    if (sel < 2) send_byte(CH_COLON);
    else if (sel < 8) begin
      send_byte(CH_EQ);
      send_value();
    end else if (sel == 8) send_byte(CH_SEMI);
    else send_byte(rand_plain_char());
    if ($urandom_range(24) == 0) send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_taken != hold_req) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected beat: kind %0d ch 0x%0h sep_code %0d number 0x%0h last %0d",
               kind_o, ch_o, sep_code_o, number_o, last_o);
        mismatches++;
      end else begin
        want = token_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("ch", want.ch, ch_o);
        check_field("sep_code", want.sep, sep_code_o);
        check_field("number", want.number, number_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("key_value_text_tokenizer: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Names, colon, equals with signed and quoted values, lone separators, a rejected name.
  task automatic test_tokens();
    send_text("ab:c=-42;s=\"x y\" n q=+7");
    send_byte(CH_TAB);
    send_text(": =5;a#b:");
    send_byte(CH_CR);
    send_byte(CH_NUL);
  endtask

  // Comments before a token, after a name and after an equals sign.
  task automatic test_comments();
    send_text("# c\n:#z\nw n #c\nx v= #c\n;#abc");
    send_byte(CH_NUL);
  endtask

  // End of text at token start, in a name, after an equals sign, in values and in comments.
  task automatic test_end_of_text();
    send_byte(CH_NUL);
    send_text("nm");
    send_byte(CH_NUL);
    send_text("nm =");
    send_byte(CH_NUL);
    send_text("q=\"ab");
    send_byte(CH_NUL);
    send_text("v=12");
    send_byte(CH_NUL);
    send_text("k= #x");
    send_byte(CH_NUL);
    send_text("n #x");
    send_byte(CH_NUL);
  endtask

  // Number limits, wrap-around, leading VT/FF, bare signs and trailing junk.
  task automatic test_numbers();
    send_text("a=");
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_text("-2147483648 b=4294967297 c=99999999999999999999 d=+ e=-x5 f=12ab3");
    send_text(" =3 g=2147483647");
    send_byte(CH_NUL);
  endtask

  // Top-bit and edge byte values in names and quoted values.
  task automatic test_byte_extremes();
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_EQ);
    send_byte(CH_QUOTE);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(CH_QUOTE);
    send_byte(8'h7F);
    send_byte(CH_SEMI);
    send_byte(CH_NUL);
  endtask

  // Output held off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    int target;
    send_gap_pct = 0;
    stall_pct    = 0;
    target       = bytes_sent + 120;
    hold_req++;
    while (bytes_sent < target) send_random_token();
  endtask

  task automatic test_random_stream(input int gap_pct, input int hold_pct, input int count);
    int target;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    target       = bytes_sent + count;
    while (bytes_sent < target) send_random_token();
  endtask

  initial begin
    restart_scan();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_tokens();
    test_comments();
    test_end_of_text();
    test_numbers();
    test_byte_extremes();
    test_backpressure();
    test_random_stream(0, 0, 330);
    test_random_stream(50, 0, 330);
    test_random_stream(0, 50, 330);
    test_random_stream(8, 8, 330);

    // Drain: every expected beat has to come out.
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("key_value_text_tokenizer: match");
    end else begin
      $display("key_value_text_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/kvt_pkg.sv
design/kvt_front.sv
design/kvt_queue.sv
design/kvt_back.sv
design/key_value_text_tokenizer.sv
design/kvt_checker.sv
sim/key_value_text_tokenizer_tb.sv
